// ===== rtl/integer_hash_unit_macros.svh =====
// Assertion macros for the integer hash unit.
// Included by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef INTEGER_HASH_UNIT_MACROS_SVH
`define INTEGER_HASH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IHU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihu: same-cycle check failed");
`define IHU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihu: next-cycle check failed");
`else
`define IHU_ASSERT_IMPL(label, ante, cons)
`define IHU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/ihu_pkg.sv =====
// Shared types, constants and round functions of the integer hash unit.
// No dependencies; used by the interfaces, the core and the top level.
package ihu_pkg;

  localparam int WORD_W = 32;
  localparam int SEL_W  = 3;
  localparam int STEP_W = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [SEL_W-1:0] {
    HS_DJB2      = 3'd0,
    HS_SDBM      = 3'd1,
    HS_MAGIC     = 3'd2,
    HS_SHIFT     = 3'd3,
    HS_JENKINS   = 3'd4,
    HS_SHIFTMULT = 3'd5
  } hash_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_MUL1,
    S_MID,
    S_MUL2,
    S_POST,
    S_JENK,
    S_DONE
  } ihu_state_t;

  typedef struct packed {
    logic  valid;
    word_t hash;
  } ihu_res_t;

  // 5381 * 33
  localparam word_t DJB2_BASE    = 32'd177573;
  // 1 + 2^6 + 2^16 - 2
  localparam word_t SDBM_MULT    = 32'd65599;
  localparam word_t MAGIC_MULT   = 32'h045d9f3b;
  localparam word_t SHIFT_MULT1  = 32'd5;
  localparam word_t SHIFT_MULT2  = 32'd2057;
  localparam word_t SM_MULT1     = 32'd9;
  localparam word_t SM_MULT2     = 32'h27d4eb2d;
  localparam word_t SM_SEED      = 32'd61;
  localparam step_t JENK_LAST    = 3'd5;

  function automatic word_t fold_abs(word_t v);
    return v[WORD_W-1] ? (word_t'(0) - v) : v;
  endfunction

  // One of the six Jenkins mixing rounds.
  function automatic word_t jenkins_round(step_t step, word_t v);
    word_t r;
    r = v;
    unique case (step)
      3'd0:    r = (v + 32'h7ed55d16) + (v << 12);
      3'd1:    r = (v ^ 32'hc761c23c) ^ (v >> 19);
      3'd2:    r = (v + 32'h165667b1) + (v << 5);
      3'd3:    r = (v + 32'hd3a2646c) ^ (v << 9);
      3'd4:    r = (v + 32'hfd7046c5) + (v << 3);
      3'd5:    r = (v ^ 32'hb55a4f09) ^ (v >> 16);
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ihu_if.sv =====
// Request and result channel interfaces of the integer hash unit.
// Depends on ihu_pkg for the word width.
interface ihu_in_if import ihu_pkg::*;
  ;
  logic  valid;
  logic  ready;
  word_t word;
  logic  last_word;

  modport source(output valid, word, last_word, input ready);
  modport sink(input valid, word, last_word, output ready);
endinterface

interface ihu_out_if import ihu_pkg::*;
  ;
  logic  valid;
  logic  ready;
  word_t hash_value;

  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

// ===== rtl/ihu_mul.sv =====
// Shared 32x32 multiplier, low word of the product, one register stage.
// Depends on ihu_pkg for the word type.
module ihu_mul import ihu_pkg::*; (
  input  logic  clk,
  input  word_t a,
  input  word_t b,
  output word_t p_r
);

  word_t p_nxt;

  assign p_nxt = word_t'(a * b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== rtl/ihu_core.sv =====
// Hash sequencer: one request at a time through the shared multiplier and round logic.
// Depends on ihu_pkg, ihu_mul and integer_hash_unit_macros.svh.
`include "integer_hash_unit_macros.svh"

module ihu_core import ihu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SEL_W-1:0] hash_sel,
  input  logic             start,
  input  word_t            word,
  input  logic             last_word,
  output logic             idle,
  output ihu_res_t         res,
  input  logic             res_ready
);

  ihu_state_t state_r, state_nxt;
  word_t      word_r;
  logic       last_r;
  word_t      x_r, x_nxt;
  word_t      acc_r, acc_nxt;
  step_t      step_r, step_nxt;
  word_t      mul_b;
  word_t      p;
  word_t      t;
  word_t      post_v;
  logic       sel_ok;

  assign sel_ok = (hash_sel <= HS_SHIFTMULT);
  assign idle   = (state_r == S_IDLE);

  ihu_mul u_mul (
    .clk (clk),
    .a   (x_r),
    .b   (mul_b),
    .p_r (p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (start && idle) begin
      word_r <= word;
      last_r <= last_word;
    end
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    mul_b     = '0;
    t         = '0;
    post_v    = x_r;
    res.valid = 1'b0;
    res.hash  = x_r;

    unique case (state_r)
      S_IDLE: begin
        // drop requests with an unused select code
        if (start && sel_ok) state_nxt = S_PRE;
      end
      S_PRE: begin
        case (hash_sel_t'(hash_sel))
          HS_DJB2: begin
            x_nxt     = word_r + DJB2_BASE;
            state_nxt = S_DONE;
          end
          HS_SDBM: begin
            x_nxt     = acc_r;
            state_nxt = S_MUL1;
          end
          HS_MAGIC: begin
            x_nxt     = word_r ^ (word_r >> 16);
            state_nxt = S_MUL1;
          end
          HS_SHIFT: begin
            t         = ~word_r + (word_r << 15);
            x_nxt     = t ^ (t >> 12);
            state_nxt = S_MUL1;
          end
          HS_JENKINS: begin
            x_nxt     = jenkins_round(3'd0, word_r);
            step_nxt  = 3'd1;
            state_nxt = S_JENK;
          end
          HS_SHIFTMULT: begin
            x_nxt     = (word_r ^ SM_SEED) ^ (word_r >> 16);
            state_nxt = S_MUL1;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MUL1: begin
        case (hash_sel_t'(hash_sel))
          HS_SDBM:      mul_b = SDBM_MULT;
          HS_MAGIC:     mul_b = MAGIC_MULT;
          HS_SHIFT:     mul_b = SHIFT_MULT1;
          HS_SHIFTMULT: mul_b = SM_MULT1;
          default:      mul_b = '0;
        endcase
        state_nxt = S_MID;
      end
      S_MID: begin
        case (hash_sel_t'(hash_sel))
          HS_SDBM: begin
            t = p + word_r;
            if (last_r) begin
              x_nxt     = t;
              acc_nxt   = '0;
              state_nxt = S_DONE;
            end else begin
              acc_nxt   = t;
              state_nxt = S_IDLE;
            end
          end
          HS_MAGIC: begin
            x_nxt     = p ^ (p >> 16);
            state_nxt = S_MUL2;
          end
          default: begin
            x_nxt     = p ^ (p >> 4);
            state_nxt = S_MUL2;
          end
        endcase
      end
      S_MUL2: begin
        case (hash_sel_t'(hash_sel))
          HS_MAGIC:     mul_b = MAGIC_MULT;
          HS_SHIFT:     mul_b = SHIFT_MULT2;
          HS_SHIFTMULT: mul_b = SM_MULT2;
          default:      mul_b = '0;
        endcase
        state_nxt = S_POST;
      end
      S_JENK: begin
        x_nxt = jenkins_round(step_r, x_r);
        if (step_r == JENK_LAST) begin
          step_nxt  = '0;
          state_nxt = S_POST;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_POST: begin
        case (hash_sel_t'(hash_sel))
          HS_JENKINS:   post_v = x_r;
          HS_SHIFTMULT: post_v = p ^ (p >> 15);
          default:      post_v = p ^ (p >> 16);
        endcase
        x_nxt     = fold_abs(post_v);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output stage takes it
        res.valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `IHU_ASSERT_NEXT(a_start_enters_pre, start && idle && sel_ok, state_r == S_PRE)
  `IHU_ASSERT_NEXT(a_result_held, (state_r == S_DONE) && !res_ready, (state_r == S_DONE) && $stable(x_r))
  `IHU_ASSERT_NEXT(a_sdbm_last_clears, (state_r == S_MID) && (hash_sel == HS_SDBM) && last_r, acc_r == '0)
  `IHU_ASSERT_IMPL(a_jenk_step_range, state_r == S_JENK, (step_r != 3'd0) && (step_r <= JENK_LAST))

endmodule

// ===== rtl/integer_hash_unit.sv =====
// Integer hash unit: hashes 32-bit request words with djb2, sdbm, magic multiply,
// Wang shift, Jenkins or shift-multiply, picked by the 3-bit hash select register
// (reset 0, djb2). One request is in work at a time; the channel is ready only while
// the sequencer idles. Unused select codes are accepted and dropped, and sdbm gives a
// result only on the last word of a message. The sequencer shares a single 32x32
// multiplier with one register stage, used twice per word by magic, shift and
// shiftmult and once by sdbm, and the Jenkins round logic does one round a cycle.
// A finished result waits in the output register so the next request can start.
// Depends on ihu_pkg, ihu_if, ihu_mul and ihu_core.
module integer_hash_unit import ihu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ihu_in_if.sink           in_req,
  ihu_out_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [SEL_W-1:0] cfg_wdata
);

  logic [SEL_W-1:0] hash_sel_r;
  logic             out_vld_r;
  word_t            out_hash_r;
  logic             core_idle;
  ihu_res_t         res;
  logic             res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_sel_r <= HS_DJB2;
    end else if (cfg_we) begin
      hash_sel_r <= cfg_wdata;
    end
  end

  ihu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .hash_sel  (hash_sel_r),
    .start     (in_req.valid),
    .word      (in_req.word),
    .last_word (in_req.last_word),
    .idle      (core_idle),
    .res       (res),
    .res_ready (res_ready)
  );

  // hold off requests while in reset
  assign in_req.ready = core_idle && rst_n;
  assign res_ready    = !out_vld_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) out_hash_r <= res.hash;
  end

  assign out_rsp.valid      = out_vld_r;
  assign out_rsp.hash_value = out_hash_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for integer_hash_unit: drives hash requests and select
// writes, predicts every hash in a scoreboard class and compares each result.
// Depends on ihu_pkg, ihu_in_if / ihu_out_if and the integer_hash_unit RTL.
module tb_top import ihu_pkg::*;
  ;

  localparam logic [SEL_W-1:0] SEL_SPARE6 = 3'd6;
  localparam logic [SEL_W-1:0] SEL_SPARE7 = 3'd7;
  localparam int unsigned ITEM_TARGET  = 1950;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam logic [SEL_W-1:0] MODE_ORDER [0:7] = '{HS_DJB2, HS_SHIFTMULT, SEL_SPARE7,
    HS_SDBM, HS_JENKINS, HS_MAGIC, SEL_SPARE6, HS_SHIFT};

  class hash_tracker;
    logic [SEL_W-1:0] sel;
    word_t            sdbm_acc;
    word_t            pending_hashes[$];
    int unsigned      mismatches;

    function new();
      sel        = HS_DJB2;
      sdbm_acc   = '0;
      mismatches = 0;
    endfunction

    function void set_select(logic [SEL_W-1:0] v);
      sel = v;
    endfunction

    function int unsigned outstanding();
      return pending_hashes.size();
    endfunction

    // Negative results fold to their magnitude; 0x80000000 stays as it is.
    function word_t fold_negative(word_t v);
      return v[WORD_W-1] ? (32'd0 - v) : v;
    endfunction

    function word_t magic_hash(word_t w);
      word_t v;
      v = ((w >> 16) ^ w) * 32'h045d9f3b;
      v = ((v >> 16) ^ v) * 32'h045d9f3b;
      v = (v >> 16) ^ v;
      return fold_negative(v);
    endfunction

    function word_t wang_shift_hash(word_t w);
      word_t v;
      v = ~w + (w << 15);
      v = v ^ (v >> 12);
      v = v + (v << 2);
      v = v ^ (v >> 4);
      v = v * 32'd2057;
      v = v ^ (v >> 16);
      return fold_negative(v);
    endfunction

    function word_t jenkins_hash(word_t w);
      word_t v;
      v = (w + 32'h7ed55d16) + (w << 12);
      v = (v ^ 32'hc761c23c) ^ (v >> 19);
      v = (v + 32'h165667b1) + (v << 5);
      v = (v + 32'hd3a2646c) ^ (v << 9);
      v = (v + 32'hfd7046c5) + (v << 3);
      v = (v ^ 32'hb55a4f09) ^ (v >> 16);
      return fold_negative(v);
    endfunction

    function word_t shift_mult_hash(word_t w);
      word_t v;
      v = (w ^ 32'd61) ^ (w >> 16);
      v = v + (v << 3);
      v = v ^ (v >> 4);
      v = v * 32'h27d4eb2d;
      v = v ^ (v >> 15);
      return fold_negative(v);
    endfunction

    function void note_request(word_t w, logic last);
      word_t acc;
      case (sel)
        HS_DJB2:      pending_hashes.push_back(32'd5381 * 32'd33 + w);
        HS_SDBM: begin
          acc = w + (sdbm_acc << 6) + (sdbm_acc << 16) - sdbm_acc;
          if (last) begin
            pending_hashes.push_back(acc);
            sdbm_acc = '0;
          end else begin
            sdbm_acc = acc;
          end
        end
        HS_MAGIC:     pending_hashes.push_back(magic_hash(w));
        HS_SHIFT:     pending_hashes.push_back(wang_shift_hash(w));
        HS_JENKINS:   pending_hashes.push_back(jenkins_hash(w));
        HS_SHIFTMULT: pending_hashes.push_back(shift_mult_hash(w));
        default: ;
      endcase
    endfunction

    function void check_hash(word_t got);
      word_t want;
      if (pending_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hash result %h", got);
      end else begin
        want = pending_hashes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("hash mismatch: expected %h, got %h", want, got);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [SEL_W-1:0] cfg_wdata;
  logic             steady = 1'b0;
  int unsigned      hold_left = 0;
  hash_tracker      tracker = new();

  ihu_in_if  req_ch();
  ihu_out_if rsp_ch();

  integer_hash_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_rsp  (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return word_t'($urandom_range(0, 255));
      5:       return word_t'(1) << $urandom_range(0, 31);
      6:       return ~(word_t'(1) << $urandom_range(0, 31));
      default: return word_t'($urandom());
    endcase
  endfunction

  // Offer one request, hold it until accepted, then idle at random.
  task automatic send_request(input word_t w, input logic last);
    int unsigned idle;
    req_ch.valid     <= 1'b1;
    req_ch.word      <= w;
    req_ch.last_word <= last;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(w, last);
    idle = 0;
    if (!steady) while ($urandom_range(0, 99) < 33) idle++;
    if (idle != 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Drop valid and wait for all results plus the longest request in work.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_select(input logic [SEL_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_select(v);
  endtask

  initial begin : result_sink
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) tracker.check_hash(rsp_ch.hash_value);
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      k;
    int unsigned      len;
    logic             broken;
    logic [SEL_W-1:0] mode;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.word      = '0;
    req_ch.last_word = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // djb2 out of reset; last marker is ignored here
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hffff_ffff, 1'b1);
    // sdbm message, then a message left open across a mode change
    write_select(HS_SDBM);
    send_request(32'h0000_0001, 1'b0);
    send_request(32'hffff_ffff, 1'b0);
    send_request(32'h8000_0000, 1'b1);
    send_request(32'h1234_5678, 1'b0);
    send_request(32'hdead_beef, 1'b0);
    write_select(HS_MAGIC);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hffff_ffff, 1'b1);
    write_select(HS_SDBM);
    send_request(32'h0000_0055, 1'b1);
    write_select(HS_SHIFT);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hffff_ffff, 1'b0);
    write_select(HS_JENKINS);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hffff_ffff, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    write_select(HS_SHIFTMULT);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hffff_ffff, 1'b0);
    send_request(32'h7fff_ffff, 1'b0);
    // spare select codes give nothing and must leave the accumulator alone
    write_select(SEL_SPARE6);
    send_request(32'h0000_1234, 1'b1);
    write_select(SEL_SPARE7);
    send_request(32'hffff_ffff, 1'b0);
    write_select(HS_SDBM);
    send_request(32'h0000_0000, 1'b1);

    sent  = 0;
    phase = 0;
    while (sent < ITEM_TARGET) begin
      if (phase < 8) mode = MODE_ORDER[phase];
      else mode = SEL_W'($urandom_range(0, (1 << SEL_W) - 1));
      steady = (phase == 7);
      write_select(mode);
      // stall the result side so the block backs up onto its input
      if (phase % 9 == 4 && mode <= HS_SHIFTMULT) hold_left = HOLD_CYCLES;
      if (mode > HS_SHIFTMULT) begin
        repeat (6) send_request(random_word(), 1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(60, 140);
        k = 0;
        while (k < n) begin
          if (mode == HS_SDBM) begin
            len = $urandom_range(1, 8);
            // now and then a message runs on without its last marker
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len && k < n; i++) begin
              send_request(random_word(), (i == len - 1) && !broken);
              k++;
            end
          end else begin
            send_request(random_word(), 1'($urandom_range(0, 1)));
            k++;
          end
        end
        sent += n;
      end
      phase++;
    end

    steady = 1'b0;
    wait_drained();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
